### rtl/acomp_pkg.sv
// ----------------------------------------------------------------------------
// acomp_pkg
// Shared types and constants for the ARGB pixel alpha compositor.
// ----------------------------------------------------------------------------
package acomp_pkg;

	typedef logic [1:0] op_t;

	localparam op_t OP_BLEND = 2'd0;
	localparam op_t OP_SOLID = 2'd1;
	localparam op_t OP_GLYPH = 2'd2;

	typedef logic cfg_index_t;

	localparam cfg_index_t CFG_PIXEL_FORMAT   = 1'b0;
	localparam cfg_index_t CFG_BACKDROP_LEVEL = 1'b1;

	localparam logic FMT_ARGB1555 = 1'b0;
	localparam logic FMT_ARGB8888 = 1'b1;

	localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;
	localparam logic [7:0] ALPHA_NONE     = 8'h00;
	localparam logic [7:0] BACKDROP_RESET = 8'd45;
	localparam logic [8:0] ALPHA_UNITY    = 9'd256;
	localparam logic [7:0] ROUND_HALF     = 8'h80;

	typedef struct packed {
		logic       pixel_format;
		logic [7:0] backdrop_level;
	} cfg_t;

endpackage

### rtl/acomp_lane.sv
// ----------------------------------------------------------------------------
// acomp_lane
// One colour channel lerp: (d*(256-a) + s*a) >> 8 on eight-bit values.
// ----------------------------------------------------------------------------
module acomp_lane (
	input  logic [7:0] dst,
	input  logic [7:0] src,
	input  logic [7:0] alpha,
	output logic [7:0] res
);
	import acomp_pkg::*;

	logic [8:0]  inv_alpha;
	logic [16:0] dst_term;
	logic [15:0] src_term;
	logic [17:0] sum;

	always_comb begin
		inv_alpha = ALPHA_UNITY - {1'b0, alpha};
		dst_term  = {9'h000, dst} * {8'h00, inv_alpha};
		src_term  = {8'h00, src} * {8'h00, alpha};
		sum       = {1'b0, dst_term} + {2'b00, src_term};
		res       = sum[15:8];
	end

endmodule

### rtl/acomp_datapath.sv
// ----------------------------------------------------------------------------
// acomp_datapath
// Single-pass pixel logic: backdrop select, channel lerps, alpha merge and
// format packing for blend, solid and glyph operations.
// ----------------------------------------------------------------------------
module acomp_datapath (
	input  acomp_pkg::cfg_t cfg,
	input  acomp_pkg::op_t  op,
	input  logic [31:0]     dest_pixel,
	input  logic [7:0]      alpha,
	input  logic [7:0]      red,
	input  logic [7:0]      green,
	input  logic [7:0]      blue,
	output logic [31:0]     new_pixel,
	output logic            changed
);
	import acomp_pkg::*;

	logic        is_8888;
	logic        glyph;
	logic [4:0]  grey5;
	logic [31:0] dst_eff;
	logic [7:0]  dr, dg, db, da;
	logic [7:0]  sr, sg, sb;
	logic [7:0]  lr, lg, lb;
	logic [15:0] mul_a;
	logic [16:0] rnd_a;
	logic [7:0]  blend_a;
	logic [7:0]  solid_a;
	logic [31:0] blend_px;
	logic [31:0] solid_px;
	logic [31:0] pass_px;

	// backdrop and channel unpacking
	always_comb begin
		is_8888 = (cfg.pixel_format == FMT_ARGB8888);
		glyph   = (op == OP_GLYPH);
		grey5   = cfg.backdrop_level[7:3];
		if (!glyph) begin
			dst_eff = dest_pixel;
		end else if (is_8888) begin
			dst_eff = {ALPHA_OPAQUE, cfg.backdrop_level, cfg.backdrop_level,
				cfg.backdrop_level};
		end else begin
			dst_eff = {16'h0000, 1'b1, grey5, grey5, grey5};
		end
		if (is_8888) begin
			da = dst_eff[31:24];
			dr = dst_eff[23:16];
			dg = dst_eff[15:8];
			db = dst_eff[7:0];
			sr = red;
			sg = green;
			sb = blue;
		end else begin
			da = ALPHA_NONE;
			dr = {3'b000, dst_eff[14:10]};
			dg = {3'b000, dst_eff[9:5]};
			db = {3'b000, dst_eff[4:0]};
			sr = {3'b000, red[7:3]};
			sg = {3'b000, green[7:3]};
			sb = {3'b000, blue[7:3]};
		end
	end

	acomp_lane u_lane_r (.dst(dr), .src(sr), .alpha(alpha), .res(lr));
	acomp_lane u_lane_g (.dst(dg), .src(sg), .alpha(alpha), .res(lg));
	acomp_lane u_lane_b (.dst(db), .src(sb), .alpha(alpha), .res(lb));

	// alpha merge a + d - round(a*d/255)
	always_comb begin
		mul_a   = {8'h00, alpha} * {8'h00, da};
		rnd_a   = {1'b0, mul_a} + {9'h000, mul_a[15:8]} + {9'h000, ROUND_HALF};
		blend_a = alpha + da - rnd_a[15:8];
	end

	// packing and op select
	always_comb begin
		solid_a = glyph ? ALPHA_OPAQUE : alpha;
		if (is_8888) begin
			blend_px = {blend_a, lr, lg, lb};
			solid_px = {solid_a, red, green, blue};
			pass_px  = dest_pixel;
		end else begin
			blend_px = {16'h0000, dst_eff[15], lr[4:0], lg[4:0], lb[4:0]};
			solid_px = {16'h0000, (solid_a != ALPHA_NONE), red[7:3], green[7:3],
				blue[7:3]};
			pass_px  = {16'h0000, dest_pixel[15:0]};
		end
		case (op)
			OP_BLEND: begin
				new_pixel = blend_px;
				changed   = 1'b1;
			end
			OP_SOLID: begin
				new_pixel = solid_px;
				changed   = 1'b1;
			end
			OP_GLYPH: begin
				if (alpha == ALPHA_NONE) begin
					new_pixel = pass_px;
					changed   = 1'b0;
				end else if (alpha == ALPHA_OPAQUE) begin
					new_pixel = solid_px;
					changed   = 1'b1;
				end else begin
					new_pixel = blend_px;
					changed   = 1'b1;
				end
			end
			default: begin
				new_pixel = pass_px;
				changed   = 1'b0;
			end
		endcase
	end

endmodule

### rtl/argb_pixel_alpha_compositor.sv
// ----------------------------------------------------------------------------
// argb_pixel_alpha_compositor
// Per-pixel compositor: blend, solid and glyph rules in ARGB1555 or ARGB8888.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries op, dest_pixel, alpha and the
//   source colour; output channel (out_valid / out_stall) returns new_pixel
//   and changed, one result per input item, in order.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) select
//   the pixel format (index 0) and the glyph backdrop grey (index 1); they
//   are taken at once and belong to idle periods only.
//   An accepted item passes through an input register, then one pass of
//   lerp multipliers into the result register, which drives out_valid.
//   Throughput is one item per cycle while the receiver does not stall;
//   the three channel lanes and the alpha multiplier are used once per item.
//   Reset empties both registers and loads ARGB1555 with backdrop 45.
//   When the receiver stalls, the result is held; one more item can still
//   enter the input register, after which in_stall is raised.
// ----------------------------------------------------------------------------
module argb_pixel_alpha_compositor (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  acomp_pkg::op_t        op,
	input  logic [31:0]           dest_pixel,
	input  logic [7:0]            alpha,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           new_pixel,
	output logic                  changed,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  acomp_pkg::cfg_index_t cfg_index,
	input  logic [7:0]            cfg_data
);
	import acomp_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	op_t         op_s1;
	logic [31:0] dest_s1;
	logic [7:0]  alpha_s1;
	logic [7:0]  red_s1;
	logic [7:0]  green_s1;
	logic [7:0]  blue_s1;
	logic        valid_s2;
	logic [31:0] pixel_s2;
	logic        changed_s2;
	logic        adv_s2;
	logic        adv_s1;
	logic [31:0] pixel_c;
	logic        changed_c;

	assign cfg_ready = 1'b1;
	assign adv_s2    = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !adv_s2;
	assign adv_s1    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format   <= FMT_ARGB1555;
			cfg_q.backdrop_level <= BACKDROP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PIXEL_FORMAT:   cfg_q.pixel_format   <= cfg_data[0];
				CFG_BACKDROP_LEVEL: cfg_q.backdrop_level <= cfg_data;
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s2) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			op_s1    <= op;
			dest_s1  <= dest_pixel;
			alpha_s1 <= alpha;
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
	end

	acomp_datapath u_datapath (
		.cfg        (cfg_q),
		.op         (op_s1),
		.dest_pixel (dest_s1),
		.alpha      (alpha_s1),
		.red        (red_s1),
		.green      (green_s1),
		.blue       (blue_s1),
		.new_pixel  (pixel_c),
		.changed    (changed_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_s2   <= pixel_c;
			changed_s2 <= changed_c;
		end
	end

	assign out_valid = valid_s2;
	assign new_pixel = pixel_s2;
	assign changed   = changed_s2;

endmodule
